/* hw/rtl/rsr_pkg.sv */
// Shared constants, command codes and controller/datapath interface types.
`default_nettype none
package rsr_pkg;

  localparam int TEXT_DEPTH    = 64;
  localparam int PATTERN_DEPTH = 16;
  localparam int WORD_WIDTH    = 32;

  localparam int TA_W  = (TEXT_DEPTH > 1) ? $clog2(TEXT_DEPTH) : 1;
  localparam int PA_W  = (PATTERN_DEPTH > 1) ? $clog2(PATTERN_DEPTH) : 1;
  localparam int TC_W  = $clog2(TEXT_DEPTH + 1);
  localparam int PC_W  = $clog2(PATTERN_DEPTH + 1);
  localparam int SUM_W = ((TC_W > PC_W) ? TC_W : PC_W) + 1;

  typedef enum logic [1:0] {
    CMD_LOAD_TEXT    = 2'd0,
    CMD_LOAD_PATTERN = 2'd1,
    CMD_RUN          = 2'd2
  } command_t;

  typedef struct packed {
    logic load_text;
    logic load_pat;
    logic init_run;
    logic adv_j;
    logic adv_i;
    logic set_pos;
    logic rd_move;
    logic wr_move;
    logic shrink;
    logic init_emit;
    logic rd_out;
    logic emit;
    logic emit_empty;
    logic clear;
  } dp_cmd_t;

  typedef struct packed {
    logic search_ok;
    logic eq;
    logic j_last;
    logic move_more;
    logic len_zero;
    logic k_last;
  } dp_stat_t;

endpackage
`default_nettype wire

/* hw/rtl/rsr_ctrl.sv */
// Controller: sequences load, search, compaction and output of the removal run.
`default_nettype none
module rsr_ctrl (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             start,
  input  wire logic [1:0]       command,
  input  wire rsr_pkg::dp_stat_t stat,
  output rsr_pkg::dp_cmd_t      cmd,
  output logic                  busy
);
  import rsr_pkg::*;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_S_CHK,
    ST_S_RD,
    ST_S_CMP,
    ST_M_CHK,
    ST_M_RD,
    ST_M_WR,
    ST_O_CHK,
    ST_O_RD,
    ST_O_WR
  } state_t;

  state_t state, state_next;

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (start) begin
          if (command == CMD_LOAD_TEXT) begin
            cmd.load_text = 1'b1;
          end else if (command == CMD_LOAD_PATTERN) begin
            cmd.load_pat = 1'b1;
          end else if (command == CMD_RUN) begin
            cmd.init_run = 1'b1;
            state_next   = ST_S_CHK;
          end
        end
      end
      ST_S_CHK: begin
        if (stat.search_ok) begin
          state_next = ST_S_RD;
        end else begin
          cmd.init_emit = 1'b1;
          state_next    = ST_O_CHK;
        end
      end
      ST_S_RD: begin
        state_next = ST_S_CMP;
      end
      ST_S_CMP: begin
        if (!stat.eq) begin
          cmd.adv_i  = 1'b1;
          state_next = ST_S_CHK;
        end else if (stat.j_last) begin
          cmd.set_pos = 1'b1;
          state_next  = ST_M_CHK;
        end else begin
          cmd.adv_j  = 1'b1;
          state_next = ST_S_RD;
        end
      end
      ST_M_CHK: begin
        if (stat.move_more) begin
          state_next = ST_M_RD;
        end else begin
          cmd.shrink = 1'b1;
          state_next = ST_S_CHK;
        end
      end
      ST_M_RD: begin
        cmd.rd_move = 1'b1;
        state_next  = ST_M_WR;
      end
      ST_M_WR: begin
        cmd.wr_move = 1'b1;
        state_next  = ST_M_CHK;
      end
      ST_O_CHK: begin
        if (stat.len_zero) begin
          cmd.emit_empty = 1'b1;
          cmd.clear      = 1'b1;
          state_next     = ST_IDLE;
        end else begin
          state_next = ST_O_RD;
        end
      end
      ST_O_RD: begin
        cmd.rd_out = 1'b1;
        state_next = ST_O_WR;
      end
      ST_O_WR: begin
        cmd.emit = 1'b1;
        if (stat.k_last) begin
          cmd.clear  = 1'b1;
          state_next = ST_IDLE;
        end else begin
          state_next = ST_O_RD;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      busy  <= 1'b0;
    end else begin
      state <= state_next;
      busy  <= (state_next != ST_IDLE);
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/rsr_dp.sv */
// Datapath: text and pattern memories, counters, match compare and output word.
`default_nettype none
module rsr_dp (
  input  wire logic                                   clk,
  input  wire logic                                   rst,
  input  wire rsr_pkg::dp_cmd_t                       cmd,
  input  wire logic signed [rsr_pkg::WORD_WIDTH-1:0]  value,
  output rsr_pkg::dp_stat_t                           stat,
  output logic                                        result_valid,
  output logic signed [rsr_pkg::WORD_WIDTH-1:0]       word,
  output logic                                        last,
  output logic                                        empty_res,
  output logic                                        overflow
);
  import rsr_pkg::*;

  logic [WORD_WIDTH-1:0] text_mem [TEXT_DEPTH];
  logic [WORD_WIDTH-1:0] pat_mem  [PATTERN_DEPTH];
  logic [WORD_WIDTH-1:0] text_rd;
  logic [WORD_WIDTH-1:0] pat_rd;

  logic [TC_W-1:0] text_count;
  logic [PC_W-1:0] pattern_count;
  logic            dropped;
  logic [TC_W-1:0] len;
  logic [TC_W-1:0] i;
  logic [PC_W-1:0] j;
  logic [TC_W-1:0] k;

  logic [SUM_W-1:0] plen_s;
  logic [SUM_W-1:0] len_s;
  logic [SUM_W-1:0] rd_sum;
  logic [TA_W-1:0]  rd_addr;
  logic [TA_W-1:0]  wr_addr;
  logic             text_full;
  logic             pat_full;

  assign plen_s    = SUM_W'(pattern_count);
  assign len_s     = SUM_W'(len);
  assign text_full = (text_count == TC_W'(TEXT_DEPTH));
  assign pat_full  = (pattern_count == PC_W'(PATTERN_DEPTH));

  always_comb begin
    if (cmd.rd_move) begin
      rd_sum = SUM_W'(k) + plen_s;
    end else if (cmd.rd_out) begin
      rd_sum = SUM_W'(k);
    end else begin
      rd_sum = SUM_W'(i) + SUM_W'(j);
    end
    rd_addr = rd_sum[TA_W-1:0];
    wr_addr = cmd.wr_move ? k[TA_W-1:0] : text_count[TA_W-1:0];
  end

  assign stat.search_ok = (pattern_count != '0) && ((SUM_W'(i) + plen_s) <= len_s);
  assign stat.eq        = (text_rd == pat_rd);
  assign stat.j_last    = ((SUM_W'(j) + SUM_W'(1)) == plen_s);
  assign stat.move_more = ((SUM_W'(k) + plen_s) < len_s);
  assign stat.len_zero  = (len == '0);
  assign stat.k_last    = ((SUM_W'(k) + SUM_W'(1)) == len_s);

  // memories
  always_ff @(posedge clk) begin
    if ((cmd.load_text && !text_full) || cmd.wr_move) begin
      text_mem[wr_addr] <= cmd.wr_move ? text_rd : value;
    end
    if (cmd.load_pat && !pat_full) begin
      pat_mem[pattern_count[PA_W-1:0]] <= value;
    end
    text_rd <= text_mem[rd_addr];
    pat_rd  <= pat_mem[j[PA_W-1:0]];
  end

  // counters and flags
  always_ff @(posedge clk) begin
    if (rst) begin
      text_count    <= '0;
      pattern_count <= '0;
      dropped       <= 1'b0;
      result_valid  <= 1'b0;
    end else begin
      result_valid <= cmd.emit || cmd.emit_empty;
      if (cmd.clear) begin
        text_count    <= '0;
        pattern_count <= '0;
        dropped       <= 1'b0;
      end else if (cmd.load_text) begin
        if (text_full) begin
          dropped <= 1'b1;
        end else begin
          text_count <= text_count + TC_W'(1);
        end
      end else if (cmd.load_pat) begin
        if (pat_full) begin
          dropped <= 1'b1;
        end else begin
          pattern_count <= pattern_count + PC_W'(1);
        end
      end
    end
  end

  // run indices and result word
  always_ff @(posedge clk) begin
    if (cmd.init_run) begin
      len <= text_count;
    end else if (cmd.shrink) begin
      len <= TC_W'(len_s - plen_s);
    end
    if (cmd.init_run || cmd.shrink) begin
      i <= '0;
      j <= '0;
    end else if (cmd.adv_i) begin
      i <= i + TC_W'(1);
      j <= '0;
    end else if (cmd.adv_j) begin
      j <= j + PC_W'(1);
    end
    if (cmd.set_pos) begin
      k <= i;
    end else if (cmd.init_emit) begin
      k <= '0;
    end else if (cmd.wr_move || cmd.emit) begin
      k <= k + TC_W'(1);
    end
    if (cmd.emit) begin
      word      <= text_rd;
      last      <= stat.k_last;
      empty_res <= 1'b0;
      overflow  <= dropped;
    end else if (cmd.emit_empty) begin
      word      <= '0;
      last      <= 1'b1;
      empty_res <= 1'b1;
      overflow  <= dropped;
    end
  end

endmodule
`default_nettype wire

/* hw/rtl/repeated_subsequence_removal.sv */
// Top level: repeated pattern removal, controller plus datapath.
//
//   channel  | handshake                | payload
//   ---------+--------------------------+------------------------------------
//   input    | start, busy (take: start & !busy) | command, value
//   result   | result_valid (one cycle) | word, last, empty_res, overflow
//
// A load word leaves busy low, so loads go back to back.
// A run checks each start position (and once more when no match is left), compares
// the pattern word by word, moves the words after each match down, closes each match,
// enters output and emits each word; every read goes through the registered read of
// the one text memory port. Busy is high from the run until its last word goes out.
// Synchronous reset clears the counts, the overflow flag and the controller.
// The receiver cannot stall: each result word is shown for one cycle.
`default_nettype none
module repeated_subsequence_removal (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  input  wire logic                                  start,
  output logic                                       busy,
  input  wire logic [1:0]                            command,
  input  wire logic signed [rsr_pkg::WORD_WIDTH-1:0] value,
  output logic                                       result_valid,
  output logic signed [rsr_pkg::WORD_WIDTH-1:0]      word,
  output logic                                       last,
  output logic                                       empty_res,
  output logic                                       overflow
);
  import rsr_pkg::*;

  dp_cmd_t  cmd;
  dp_stat_t stat;

  rsr_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .start   (start),
    .command (command),
    .stat    (stat),
    .cmd     (cmd),
    .busy    (busy)
  );

  rsr_dp u_dp (
    .clk          (clk),
    .rst          (rst),
    .cmd          (cmd),
    .value        (value),
    .stat         (stat),
    .result_valid (result_valid),
    .word         (word),
    .last         (last),
    .empty_res    (empty_res),
    .overflow     (overflow)
  );

endmodule
`default_nettype wire

/* tb/tb_top.sv */
// Testbench for repeated_subsequence_removal: load/run word sequences checked against a predictor.
`default_nettype none
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rsr_pkg::*;

  localparam logic [1:0] CMD_UNUSED = 2'd3;
  localparam int CYCLE_LIMIT = 3_000_000;
  localparam int ITEM_TARGET = 460;
  localparam int DRAIN_CYCLES = 20;

  typedef logic signed [WORD_WIDTH-1:0] word_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_WIDTH-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_WIDTH-1){1'b0}}};

  typedef struct {
    word_t word;
    logic  last;
    logic  empty_res;
    logic  overflow;
  } out_word_t;

  // Tracks text/pattern stores and queues the reduced text expected per run.
  class removal_checker;
    word_t text_mem[TEXT_DEPTH];
    word_t pat_mem[PATTERN_DEPTH];
    int text_len = 0;
    int pat_len = 0;
    bit dropped = 1'b0;
    out_word_t reduced_words[$];
    int mismatches = 0;

    function int leftmost_match(int len);
      int j;
      if (pat_len == 0 || pat_len > len) return -1;
      for (int i = 0; i + pat_len <= len; i++) begin
        for (j = 0; j < pat_len; j++) begin
          if (text_mem[i+j] !== pat_mem[j]) break;
        end
        if (j == pat_len) return i;
      end
      return -1;
    endfunction

    function void reduce_text();
      int len;
      int pos;
      out_word_t w;
      len = text_len;
      pos = leftmost_match(len);
      while (pos >= 0) begin
        for (int k = pos; k + pat_len < len; k++) text_mem[k] = text_mem[k+pat_len];
        len -= pat_len;
        pos = leftmost_match(len);
      end
      if (len == 0) begin
        w.word = '0;
        w.last = 1'b1;
        w.empty_res = 1'b1;
        w.overflow = dropped;
        reduced_words.push_back(w);
      end else begin
        for (int k = 0; k < len; k++) begin
          w.word = text_mem[k];
          w.last = (k == len - 1);
          w.empty_res = 1'b0;
          w.overflow = dropped;
          reduced_words.push_back(w);
        end
      end
      text_len = 0;
      pat_len = 0;
      dropped = 1'b0;
    endfunction

    function void note_word(logic [1:0] cmd, word_t val);
      case (cmd)
        CMD_LOAD_TEXT: begin
          if (text_len < TEXT_DEPTH) text_mem[text_len++] = val;
          else dropped = 1'b1;
        end
        CMD_LOAD_PATTERN: begin
          if (pat_len < PATTERN_DEPTH) pat_mem[pat_len++] = val;
          else dropped = 1'b1;
        end
        CMD_RUN: reduce_text();
        default: ;
      endcase
    endfunction

    function void check_word(word_t word, logic last, logic empty_res, logic overflow);
      out_word_t w;
      if (reduced_words.size() == 0) begin
        $error("unexpected result word: word %0d last %0b", word, last);
        mismatches++;
        return;
      end
      w = reduced_words.pop_front();
      if (word !== w.word) begin
        $error("word mismatch: expected %0d, got %0d", w.word, word);
        mismatches++;
      end
      if (last !== w.last) begin
        $error("last mismatch: expected %0b, got %0b", w.last, last);
        mismatches++;
      end
      if (empty_res !== w.empty_res) begin
        $error("empty_res mismatch: expected %0b, got %0b", w.empty_res, empty_res);
        mismatches++;
      end
      if (overflow !== w.overflow) begin
        $error("overflow mismatch: expected %0b, got %0b", w.overflow, overflow);
        mismatches++;
      end
    endfunction
  endclass

  logic clk;
  logic rst;
  logic start;
  logic busy;
  logic [1:0] command;
  word_t value;
  logic result_valid;
  word_t word;
  logic last;
  logic empty_res;
  logic overflow;

  removal_checker board = new();
  int items_sent = 0;
  bit idle_on = 1'b1;

  repeated_subsequence_removal u_dut (
    .clk(clk),
    .rst(rst),
    .start(start),
    .busy(busy),
    .command(command),
    .value(value),
    .result_valid(result_valid),
    .word(word),
    .last(last),
    .empty_res(empty_res),
    .overflow(overflow)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    if (!rst && result_valid) board.check_word(word, last, empty_res, overflow);
  end

  task automatic send(logic [1:0] cmd, word_t val);
    if (idle_on && $urandom_range(99) < 6) begin
      repeat ($urandom_range(1, 4)) begin
        @(negedge clk);
        start <= 1'b0;
      end
    end
    @(negedge clk);
    start <= 1'b1;
    command <= cmd;
    value <= val;
    do @(posedge clk); while (busy);
    board.note_word(cmd, val);
    if (cmd != CMD_UNUSED) items_sent++;
  endtask

  task automatic wait_drained();
    @(negedge clk);
    start <= 1'b0;
    while (board.reduced_words.size() != 0) @(posedge clk);
  endtask

  // structured: text built from pattern copies and a 3-word alphabet
  task automatic run_sequence(int text_target, int pat_target, bit structured);
    word_t alphabet[3];
    word_t pat_q[$];
    word_t text_q[$];
    int ti;
    int pi;
    int at;
    for (int i = 0; i < 3; i++) alphabet[i] = word_t'($urandom);
    if (structured) begin
      for (int i = 0; i < pat_target; i++) pat_q.push_back(alphabet[$urandom_range(2)]);
      while (text_q.size() < text_target) begin
        at = $urandom_range(text_q.size());
        if (pat_q.size() > 0 && $urandom_range(1) == 0) begin
          for (int j = pat_q.size() - 1; j >= 0; j--) text_q.insert(at, pat_q[j]);
        end else begin
          text_q.insert(at, alphabet[$urandom_range(2)]);
        end
      end
    end else begin
      for (int i = 0; i < text_target; i++) text_q.push_back(word_t'($urandom));
      if (pat_target > 0 && pat_target <= text_target && $urandom_range(1) == 0) begin
        at = $urandom_range(text_target - pat_target);
        for (int i = 0; i < pat_target; i++) pat_q.push_back(text_q[at+i]);
      end else begin
        for (int i = 0; i < pat_target; i++) pat_q.push_back(word_t'($urandom));
      end
    end
    ti = 0;
    pi = 0;
    while (ti < text_q.size() || pi < pat_q.size()) begin
      if ($urandom_range(19) == 0) send(CMD_UNUSED, word_t'($urandom));
      if (pi < pat_q.size() && (ti == text_q.size() || $urandom_range(3) == 0)) begin
        send(CMD_LOAD_PATTERN, pat_q[pi]);
        pi++;
      end else begin
        send(CMD_LOAD_TEXT, text_q[ti]);
        ti++;
      end
    end
    send(CMD_RUN, word_t'($urandom));
  endtask

  initial begin
    int seq_count;
    int pick;
    int t;
    rst = 1'b1;
    start = 1'b0;
    command = CMD_LOAD_TEXT;
    value = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    // nothing loaded: single empty word
    send(CMD_RUN, WORD_MIN);
    // extremes, pattern matched twice
    send(CMD_LOAD_TEXT, WORD_MAX);
    send(CMD_LOAD_PATTERN, WORD_MAX);
    send(CMD_LOAD_TEXT, WORD_MIN);
    send(CMD_LOAD_TEXT, WORD_MAX);
    send(CMD_LOAD_PATTERN, WORD_MIN);
    send(CMD_LOAD_TEXT, WORD_MIN);
    send(CMD_LOAD_TEXT, -1);
    send(CMD_RUN, WORD_MAX);
    wait_drained();
    send(CMD_UNUSED, WORD_MAX);
    // empty pattern
    send(CMD_LOAD_TEXT, 0);
    send(CMD_LOAD_TEXT, 1);
    send(CMD_LOAD_TEXT, 2);
    send(CMD_RUN, 0);
    // pattern longer than text
    send(CMD_LOAD_TEXT, 9);
    send(CMD_LOAD_PATTERN, 9);
    send(CMD_LOAD_PATTERN, 9);
    send(CMD_RUN, 0);
    // nested occurrence removes everything
    send(CMD_LOAD_TEXT, 1);
    send(CMD_LOAD_TEXT, 1);
    send(CMD_LOAD_TEXT, 2);
    send(CMD_LOAD_TEXT, 2);
    send(CMD_LOAD_PATTERN, 1);
    send(CMD_LOAD_PATTERN, 2);
    send(CMD_RUN, -1);

    seq_count = 0;
    while (items_sent < ITEM_TARGET) begin
      idle_on = !(items_sent >= 200 && items_sent < 320);
      pick = $urandom_range(99);
      if (seq_count == 0) begin
        run_sequence($urandom_range(65, 70), $urandom_range(1, 3), 1'b1);
      end else if (seq_count == 1) begin
        run_sequence($urandom_range(5, 20), $urandom_range(17, 19), 1'b1);
      end else if (pick < 60) begin
        run_sequence($urandom_range(0, 20), $urandom_range(1, 4), 1'b1);
      end else if (pick < 68) begin
        run_sequence($urandom_range(30, 64), $urandom_range(1, 16), 1'b1);
      end else if (pick < 78) begin
        run_sequence($urandom_range(0, 12), $urandom_range(0, 3), 1'b0);
      end else if (pick < 85) begin
        run_sequence($urandom_range(1, 10), 0, 1'b1);
      end else if (pick < 93) begin
        t = $urandom_range(0, 3);
        run_sequence(t, $urandom_range(t + 1, 6), 1'b0);
      end else if (pick < 97) begin
        run_sequence($urandom_range(65, 68), $urandom_range(1, 3), 1'b1);
      end else begin
        run_sequence($urandom_range(5, 20), $urandom_range(17, 18), 1'b1);
      end
      if ($urandom_range(9) == 0) wait_drained();
      seq_count++;
    end

    wait_drained();
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (board.mismatches == 0 && board.reduced_words.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

  initial begin
    int cycles;
    cycles = 0;
    while (cycles < CYCLE_LIMIT) begin
      @(posedge clk);
      cycles++;
    end
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
